@@ hdl/vector_mac_accumulator_macros.svh @@
// Assertion macros shared by the vector multiply-accumulate block.
`ifndef VECTOR_MAC_ACCUMULATOR_MACROS_SVH
`define VECTOR_MAC_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and silent while arst_n is low.
`define VMA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vma: same-cycle check failed");

// Next-cycle implication, sampled on clk and silent while arst_n is low.
`define VMA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vma: next-cycle check failed");

`endif

@@ hdl/vma_pkg.sv @@
// Package of the vector multiply-accumulate block: sizes, codes and types.
package vma_pkg;

	localparam int LANES     = 4;
	localparam int WORD_BITS = 16;
	localparam int IN_WORDS  = 4;
	localparam int IN_BITS   = 16;
	localparam int CNT_BITS  = 3;
	localparam int KIND_BITS = 4;
	localparam int ACC_BITS  = 64;

	// Only as many lanes as an item has words can ever be busy.
	localparam int NUM_LANES = (LANES < IN_WORDS) ? LANES : IN_WORDS;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int SUM_BITS  = PROD_BITS + $clog2(NUM_LANES) + 1;

	typedef logic [KIND_BITS-1:0] kind_t;

	localparam kind_t KIND_IDLE     = 4'd0;
	localparam kind_t KIND_ADD      = 4'd1;
	localparam kind_t KIND_SUB      = 4'd2;
	localparam kind_t KIND_VADD     = 4'd3;
	localparam kind_t KIND_VSUB     = 4'd4;
	localparam kind_t KIND_CAPTURE  = 4'd5;
	localparam kind_t KIND_VMAC_ADD = 4'd6;
	localparam kind_t KIND_VMAC_SUB = 4'd7;
	localparam kind_t KIND_SQ_ADD   = 4'd8;
	localparam kind_t KIND_SQ_SUB   = 4'd9;

	typedef enum logic [1:0] {
		LOP_NONE   = 2'd0,
		LOP_WORD   = 2'd1,
		LOP_MAC    = 2'd2,
		LOP_SQUARE = 2'd3
	} lane_op_t;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [PROD_BITS-1:0] term_t;
	typedef logic signed [SUM_BITS-1:0]  sum_t;
	typedef logic [ACC_BITS-1:0]         acc_t;

	typedef struct packed {
		logic adv;
		logic acc_en;
		logic sub;
	} merge_ctl_t;

endpackage

@@ hdl/vma_lane.sv @@
// One lane: selects a word, an operand product or a square and registers the term.
module vma_lane (
	input  logic              clk,
	input  logic              adv,
	input  vma_pkg::lane_op_t op,
	input  vma_pkg::word_t    word,
	input  vma_pkg::word_t    operand,
	output vma_pkg::term_t    term_s1
);

	vma_pkg::word_t mul_a;
	vma_pkg::term_t prod;
	vma_pkg::term_t term_c;

	always_comb begin
		mul_a = (op == vma_pkg::LOP_SQUARE) ? word : operand;
		prod  = mul_a * word;
		case (op)
			vma_pkg::LOP_WORD: begin
				term_c = {{(vma_pkg::PROD_BITS-vma_pkg::WORD_BITS){word[vma_pkg::WORD_BITS-1]}},
					word};
			end
			vma_pkg::LOP_MAC, vma_pkg::LOP_SQUARE: begin
				term_c = prod;
			end
			default: begin
				term_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			term_s1 <= term_c;
		end
	end

endmodule

@@ hdl/vma_merge.sv @@
// Merging stage: adds the lane terms, then adds or subtracts the sum into the accumulator.
module vma_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  vma_pkg::merge_ctl_t ctl,
	input  vma_pkg::term_t      terms_s1 [vma_pkg::NUM_LANES],
	output vma_pkg::acc_t       total
);

	vma_pkg::sum_t sum_c;
	vma_pkg::sum_t sum_s2;
	vma_pkg::acc_t sum_ext;
	vma_pkg::acc_t acc_q;

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < vma_pkg::NUM_LANES; i++) begin
			sum_c = sum_c + {{(vma_pkg::SUM_BITS-vma_pkg::PROD_BITS)
				{terms_s1[i][vma_pkg::PROD_BITS-1]}}, terms_s1[i]};
		end
		sum_ext = {{(vma_pkg::ACC_BITS-vma_pkg::SUM_BITS){sum_s2[vma_pkg::SUM_BITS-1]}}, sum_s2};
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			sum_s2 <= sum_c;
		end
	end

	// The accumulator wraps modulo 2^64.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= ctl.sub ? (acc_q - sum_ext) : (acc_q + sum_ext);
		end
	end

	assign total = acc_q;

endmodule

@@ hdl/vector_mac_accumulator.sv @@
// Vector multiply-accumulate block: decode, operand vector, lane array and output control.
//
// Items arrive on item_valid/item_stall with a kind, a word count and four signed
// words; one result word per item leaves on result_valid/result_stall carrying the
// 64-bit wrapping accumulator and the operand vector length after that item.
// A word moves when its valid is high and its stall is low.
// From acceptance to result_valid, lane terms are registered, the merging adder tree
// is registered, then the accumulator updates.
// Throughput is one item per cycle while the pipeline is not frozen, set by the
// accumulator add and the lane multipliers, one per lane, that take a new word every cycle.
// Capture loads the operand vector at acceptance, so the very next item sees it.
// cfg_write loads cfg_data into the multiplier enable; while it is zero, capture,
// vector multiply-accumulate and square kinds act as idle.
// When result_stall holds a waiting result, the whole pipeline freezes and
// item_stall is raised; bubbles do not squeeze out while frozen.
// Reset clears the accumulator, the operand vector and its length, sets the
// multiplier enable and empties the pipeline.
`include "vector_mac_accumulator_macros.svh"

module vector_mac_accumulator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic                            cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [vma_pkg::KIND_BITS-1:0]   kind,
	input  logic [vma_pkg::CNT_BITS-1:0]    word_count,
	input  logic signed [vma_pkg::IN_BITS-1:0] word0,
	input  logic signed [vma_pkg::IN_BITS-1:0] word1,
	input  logic signed [vma_pkg::IN_BITS-1:0] word2,
	input  logic signed [vma_pkg::IN_BITS-1:0] word3,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic signed [vma_pkg::ACC_BITS-1:0] total,
	output logic [vma_pkg::CNT_BITS-1:0]    operand_length
);

	logic                         mul_en_q;
	logic                         adv;
	logic                         item_acc;
	logic [vma_pkg::CNT_BITS-1:0] n_words;
	logic                         sub_c;
	logic                         capture_c;
	vma_pkg::word_t               words [vma_pkg::IN_WORDS];
	vma_pkg::word_t               operand_q [vma_pkg::NUM_LANES];
	logic [vma_pkg::CNT_BITS-1:0] op_cnt_q;
	vma_pkg::lane_op_t            lane_op [vma_pkg::NUM_LANES];
	vma_pkg::term_t               terms_s1 [vma_pkg::NUM_LANES];
	logic                         v_s1, v_s2;
	logic                         sub_s1, sub_s2;
	logic [vma_pkg::CNT_BITS-1:0] len_s1, len_s2, len_q;
	logic                         result_valid_q;
	logic                         acc_en;
	vma_pkg::merge_ctl_t          mctl;
	vma_pkg::acc_t                acc_total;

	assign adv        = !(result_valid_q && result_stall);
	assign item_stall = !adv;
	assign item_acc   = item_valid && adv;

	// Only the low WORD_BITS of each input word count.
	assign words[0] = word0[vma_pkg::WORD_BITS-1:0];
	assign words[1] = word1[vma_pkg::WORD_BITS-1:0];
	assign words[2] = word2[vma_pkg::WORD_BITS-1:0];
	assign words[3] = word3[vma_pkg::WORD_BITS-1:0];

	assign n_words = (word_count > vma_pkg::CNT_BITS'(vma_pkg::NUM_LANES))
		? vma_pkg::CNT_BITS'(vma_pkg::NUM_LANES) : word_count;

	always_comb begin
		sub_c     = 1'b0;
		capture_c = 1'b0;
		for (int i = 0; i < vma_pkg::NUM_LANES; i++) begin
			lane_op[i] = vma_pkg::LOP_NONE;
		end
		unique case (kind) inside
			vma_pkg::KIND_ADD, vma_pkg::KIND_SUB: begin
				sub_c = (kind == vma_pkg::KIND_SUB);
				if (n_words != '0) begin
					lane_op[0] = vma_pkg::LOP_WORD;
				end
			end
			vma_pkg::KIND_VADD, vma_pkg::KIND_VSUB: begin
				sub_c = (kind == vma_pkg::KIND_VSUB);
				for (int i = 0; i < vma_pkg::NUM_LANES; i++) begin
					if (vma_pkg::CNT_BITS'(i) < n_words) begin
						lane_op[i] = vma_pkg::LOP_WORD;
					end
				end
			end
			vma_pkg::KIND_CAPTURE: begin
				capture_c = mul_en_q && (n_words != '0);
			end
			vma_pkg::KIND_VMAC_ADD, vma_pkg::KIND_VMAC_SUB: begin
				if (mul_en_q) begin
					sub_c = (kind == vma_pkg::KIND_VMAC_SUB);
					for (int i = 0; i < vma_pkg::NUM_LANES; i++) begin
						if (vma_pkg::CNT_BITS'(i) < n_words &&
							vma_pkg::CNT_BITS'(i) < op_cnt_q) begin
							lane_op[i] = vma_pkg::LOP_MAC;
						end
					end
				end
			end
			vma_pkg::KIND_SQ_ADD, vma_pkg::KIND_SQ_SUB: begin
				if (mul_en_q) begin
					sub_c = (kind == vma_pkg::KIND_SQ_SUB);
					for (int i = 0; i < vma_pkg::NUM_LANES; i++) begin
						if (vma_pkg::CNT_BITS'(i) < n_words) begin
							lane_op[i] = vma_pkg::LOP_SQUARE;
						end
					end
				end
			end
			default: begin
				sub_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_en_q <= 1'b1;
		end else if (cfg_write) begin
			mul_en_q <= cfg_data;
		end
	end

	// Entries past the loaded count are cleared on capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_cnt_q <= '0;
			for (int i = 0; i < vma_pkg::NUM_LANES; i++) begin
				operand_q[i] <= '0;
			end
		end else if (item_acc && capture_c) begin
			op_cnt_q <= n_words;
			for (int i = 0; i < vma_pkg::NUM_LANES; i++) begin
				operand_q[i] <= (vma_pkg::CNT_BITS'(i) < n_words) ? words[i] : '0;
			end
		end
	end

	for (genvar g = 0; g < vma_pkg::NUM_LANES; g++) begin : g_lane
		vma_lane u_lane (
			.clk     (clk),
			.adv     (adv),
			.op      (item_acc ? lane_op[g] : vma_pkg::LOP_NONE),
			.word    (words[g]),
			.operand (operand_q[g]),
			.term_s1 (terms_s1[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1           <= item_acc;
			v_s2           <= v_s1;
			result_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sub_s1 <= sub_c;
			len_s1 <= capture_c ? n_words : op_cnt_q;
			sub_s2 <= sub_s1;
			len_s2 <= len_s1;
			len_q  <= len_s2;
		end
	end

	assign acc_en      = adv && v_s2;
	assign mctl.adv    = adv;
	assign mctl.acc_en = acc_en;
	assign mctl.sub    = sub_s2;

	vma_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mctl),
		.terms_s1 (terms_s1),
		.total    (acc_total)
	);

	assign total          = acc_total;
	assign result_valid   = result_valid_q;
	assign operand_length = len_q;

	`VMA_ASSERT_IMP(a_stall_only_on_held_result, item_stall, result_valid)
	`VMA_ASSERT_IMP(a_len_in_range, 1'b1, op_cnt_q <= vma_pkg::CNT_BITS'(vma_pkg::NUM_LANES))
	`VMA_ASSERT_NEXT(a_s2_reaches_output, adv && v_s2, result_valid)
	`VMA_ASSERT_NEXT(a_acc_only_on_item, !acc_en, $stable(total))
	`VMA_ASSERT_NEXT(a_no_capture_when_off, item_acc && !mul_en_q, $stable(op_cnt_q))

endmodule
